@@ rtl/crsp_pkg.sv @@
// Shared widths, types and constants for the Catmull-Rom spline point block.
package crsp_pkg;

   localparam int COORD_W     = 32;              // Q16.16 coordinate
   localparam int PARAM_W     = 17;              // Q1.16 parameter, 1.0 included
   localparam int NUM_PTS     = 4;
   localparam int NUM_LANES   = 2;               // one lane per axis
   localparam int LANE_STAGES = 8;
   localparam int NUM_STG     = LANE_STAGES + 1; // plus the output register
   localparam int Q_W         = 37;              // rounded value before clipping

   localparam int REQ_FIELDS_W = NUM_PTS * NUM_LANES * COORD_W + PARAM_W;
   localparam int REQ_W        = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = NUM_LANES * COORD_W + 1;
   localparam int RSP_W        = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(65536);
   localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [PARAM_W-1:0]        param_type;
   typedef logic signed [Q_W-1:0]     q_type;

   typedef struct packed {
      logic [LANE_STAGES-1:0] lane_en;
      logic                   out_en;
   } stage_ctl_type;

endpackage

@@ rtl/crsp_lane.sv @@
// One axis of the spline: Horner evaluation of the cubic, exact, then rounded.
module crsp_lane (
   input  logic                   clock,
   input  crsp_pkg::stage_ctl_type ctl,
   input  crsp_pkg::coord_type    p1,
   input  crsp_pkg::coord_type    p2,
   input  crsp_pkg::coord_type    p3,
   input  crsp_pkg::coord_type    p4,
   input  crsp_pkg::param_type    param_s,
   output crsp_pkg::q_type        q
);
   import crsp_pkg::*;

   // stage 1: differences
   logic signed [32:0] a1_ff, b1_ff, d1_ff;
   logic signed [32:0] a1_in, b1_in, d1_in;
   coord_type          p2_1_ff;
   param_type          s1_ff, s1_in;

   // stage 2: cubic and quadratic coefficients
   logic signed [36:0] c2_2_ff, c3_2_ff, c2_2_in, c3_2_in;
   logic signed [36:0] d37;
   logic signed [32:0] a2_ff;
   coord_type          p2_2_ff;
   param_type          s2_ff;

   // stage 3: C3 * s
   logic signed [54:0] m1_3_ff, m1_3_in;
   logic signed [36:0] c2_3_ff;
   logic signed [32:0] a3_ff;
   coord_type          p2_3_ff;
   param_type          s3_ff;

   // stage 4: + C2 << 16
   logic signed [54:0] acc1_4_ff, acc1_4_in;
   logic signed [32:0] a4_ff;
   coord_type          p2_4_ff;
   param_type          s4_ff;

   // stage 5: acc1 * s in two partial products
   logic [44:0]        m2lo_5_ff, m2lo_5_in;
   logic signed [44:0] m2hi_5_ff, m2hi_5_in;
   logic signed [32:0] a5_ff;
   coord_type          p2_5_ff;
   param_type          s5_ff;

   // stage 6: + A << 32
   logic signed [71:0] acc2_6_ff, acc2_6_in;
   coord_type          p2_6_ff;
   param_type          s6_ff;

   // stage 7: acc2 * s in two partial products
   logic [52:0]        m3lo_7_ff, m3lo_7_in;
   logic signed [53:0] m3hi_7_ff, m3hi_7_in;
   coord_type          p2_7_ff;

   // stage 8: + 2*p2 << 48, round, shift
   logic signed [87:0] v8;
   q_type              q_8_ff, q_8_in;

   logic signed [PARAM_W:0] s2_sg, s4_sg, s6_sg;

   assign s2_sg = $signed({1'b0, s2_ff});
   assign s4_sg = $signed({1'b0, s4_ff});
   assign s6_sg = $signed({1'b0, s6_ff});

   always_comb begin
      a1_in = 33'(p3) - 33'(p1);
      b1_in = 33'(p4) - 33'(p2);
      d1_in = 33'(p3) - 33'(p2);
      s1_in = (param_s > PARAM_ONE) ? PARAM_ONE : param_s;

      d37     = 37'(d1_ff);
      c2_2_in = (d37 <<< 2) + (d37 <<< 1) - (37'(a1_ff) <<< 1) - 37'(b1_ff);
      c3_2_in = 37'(a1_ff) + 37'(b1_ff) - (d37 <<< 2);

      m1_3_in   = 55'(c3_2_ff) * 55'(s2_sg);
      acc1_4_in = m1_3_ff + (55'(c2_3_ff) <<< 16);

      m2lo_5_in = 45'(acc1_4_ff[27:0]) * 45'(s4_ff);
      m2hi_5_in = 45'($signed(acc1_4_ff[54:28])) * 45'(s4_sg);
      acc2_6_in = (72'(m2hi_5_ff) <<< 28) + $signed(72'(m2lo_5_ff))
                + (72'(a5_ff) <<< 32);

      m3lo_7_in = 53'(acc2_6_ff[35:0]) * 53'(s6_ff);
      m3hi_7_in = 54'($signed(acc2_6_ff[71:36])) * 54'(s6_sg);

      v8 = (88'(m3hi_7_ff) <<< 36) + $signed(88'(m3lo_7_ff))
         + (88'(p2_7_ff) <<< 49) + $signed(88'(1) << 48);
      q_8_in = v8[85:49];
   end

   always_ff @(posedge clock) begin
      if (ctl.lane_en[0]) begin
         a1_ff   <= a1_in;
         b1_ff   <= b1_in;
         d1_ff   <= d1_in;
         p2_1_ff <= p2;
         s1_ff   <= s1_in;
      end
      if (ctl.lane_en[1]) begin
         c2_2_ff <= c2_2_in;
         c3_2_ff <= c3_2_in;
         a2_ff   <= a1_ff;
         p2_2_ff <= p2_1_ff;
         s2_ff   <= s1_ff;
      end
      if (ctl.lane_en[2]) begin
         m1_3_ff <= m1_3_in;
         c2_3_ff <= c2_2_ff;
         a3_ff   <= a2_ff;
         p2_3_ff <= p2_2_ff;
         s3_ff   <= s2_ff;
      end
      if (ctl.lane_en[3]) begin
         acc1_4_ff <= acc1_4_in;
         a4_ff     <= a3_ff;
         p2_4_ff   <= p2_3_ff;
         s4_ff     <= s3_ff;
      end
      if (ctl.lane_en[4]) begin
         m2lo_5_ff <= m2lo_5_in;
         m2hi_5_ff <= m2hi_5_in;
         a5_ff     <= a4_ff;
         p2_5_ff   <= p2_4_ff;
         s5_ff     <= s4_ff;
      end
      if (ctl.lane_en[5]) begin
         acc2_6_ff <= acc2_6_in;
         p2_6_ff   <= p2_5_ff;
         s6_ff     <= s5_ff;
      end
      if (ctl.lane_en[6]) begin
         m3lo_7_ff <= m3lo_7_in;
         m3hi_7_ff <= m3hi_7_in;
         p2_7_ff   <= p2_6_ff;
      end
      if (ctl.lane_en[7]) begin
         q_8_ff <= q_8_in;
      end
   end

   assign q = q_8_ff;

endmodule

@@ rtl/crsp_merge.sv @@
// Clips both axes to Q16.16, merges the clip flags and holds the result register.
module crsp_merge (
   input  logic                    clock,
   input  crsp_pkg::stage_ctl_type ctl,
   input  crsp_pkg::q_type         q_x,
   input  crsp_pkg::q_type         q_y,
   output crsp_pkg::coord_type     out_x,
   output crsp_pkg::coord_type     out_y,
   output logic                    saturated
);
   import crsp_pkg::*;

   localparam int HI_W = Q_W - COORD_W + 1;

   coord_type out_x_ff, out_x_in;
   coord_type out_y_ff, out_y_in;
   logic      sat_ff, sat_in;
   logic      fit_x, fit_y;
   logic [HI_W-1:0] hi_x, hi_y;

   always_comb begin
      // fits when the bits above the sign of a 32-bit value are all copies of it
      hi_x  = q_x[Q_W-1:COORD_W-1];
      hi_y  = q_y[Q_W-1:COORD_W-1];
      fit_x = (&hi_x) || !(|hi_x);
      fit_y = (&hi_y) || !(|hi_y);
      out_x_in = fit_x ? q_x[COORD_W-1:0] : (q_x[Q_W-1] ? COORD_MIN : COORD_MAX);
      out_y_in = fit_y ? q_y[COORD_W-1:0] : (q_y[Q_W-1] ? COORD_MIN : COORD_MAX);
      sat_in   = !fit_x || !fit_y;
   end

   always_ff @(posedge clock) begin
      if (ctl.out_en) begin
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         sat_ff   <= sat_in;
      end
   end

   assign out_x     = out_x_ff;
   assign out_y     = out_y_ff;
   assign saturated = sat_ff;

endmodule

@@ rtl/catmull_rom_spline_point.sv @@
// Top level of the 2D Catmull-Rom spline point evaluator.
//
// Usage:
//   One request transfer carries four control points p1..p4 and param_s; one
//   response transfer returns the point on the segment from p2 to p3, clipped
//   to signed Q16.16, with a flag when either axis was clipped.
//   param_s above 1.0 is treated as 1.0.
// Pipeline: a request transfer passes through the 8 lane stages, then the
//   output register, before it reaches rsp_tvalid.
// Throughput: one item per cycle while the response side is not stalled; each
//   axis has its own lane with one short multiplier for the first Horner step
//   and two for each later one, and the lanes run in lockstep.
// Reset: clears every stage valid bit; nothing is held across reset.
// Stall: a stalled response holds the output register; each stage keeps
//   accepting while an empty stage lies ahead of it, so req_tready drops only
//   once all nine stages hold items.
module catmull_rom_spline_point (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // p1_x, p1_y, p2_x, p2_y, p3_x, p3_y, p4_x, p4_y, param_s, zero fill
   input  logic [crsp_pkg::REQ_W-1:0]  req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // out_x, out_y, saturated, zero fill
   output logic [crsp_pkg::RSP_W-1:0]  rsp_tdata
);
   import crsp_pkg::*;

   localparam int S_LSB = NUM_PTS * NUM_LANES * COORD_W;

   logic [NUM_STG-1:0] vld_ff, vld_in;
   logic [NUM_STG-1:0] adv;
   stage_ctl_type      ctl;
   q_type              lane_q [NUM_LANES];
   coord_type          out_x, out_y;
   logic               saturated;
   param_type          param_s;

   // a stage may load when it is empty or its contents move on
   always_comb begin
      adv[NUM_STG-1] = !vld_ff[NUM_STG-1] || rsp_tready;
      for (int k = NUM_STG - 2; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      vld_in[0] = adv[0] ? req_tvalid : vld_ff[0];
      for (int k = 1; k < NUM_STG; k++) begin
         vld_in[k] = adv[k] ? vld_ff[k-1] : vld_ff[k];
      end
      ctl.lane_en = adv[LANE_STAGES-1:0];
      ctl.out_en  = adv[NUM_STG-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign param_s = req_tdata[S_LSB +: PARAM_W];

   for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
      crsp_lane u_lane (
         .clock   (clock),
         .ctl     (ctl),
         .p1      (req_tdata[(0 * NUM_LANES + i) * COORD_W +: COORD_W]),
         .p2      (req_tdata[(1 * NUM_LANES + i) * COORD_W +: COORD_W]),
         .p3      (req_tdata[(2 * NUM_LANES + i) * COORD_W +: COORD_W]),
         .p4      (req_tdata[(3 * NUM_LANES + i) * COORD_W +: COORD_W]),
         .param_s (param_s),
         .q       (lane_q[i])
      );
   end

   crsp_merge u_merge (
      .clock     (clock),
      .ctl       (ctl),
      .q_x       (lane_q[0]),
      .q_y       (lane_q[1]),
      .out_x     (out_x),
      .out_y     (out_y),
      .saturated (saturated)
   );

   assign req_tready = adv[0];
   assign rsp_tvalid = vld_ff[NUM_STG-1];
   assign rsp_tdata  = {(RSP_W - RSP_FIELDS_W)'(0), saturated, out_y, out_x};

   // a clipped result has at least one axis at a range limit
   a_sat_at_limit : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && saturated |->
         out_x == COORD_MAX || out_x == COORD_MIN ||
         out_y == COORD_MAX || out_y == COORD_MIN)
      else $error("saturated flag set with both axes inside range");

   // back-pressure reaches the request side only with every stage occupied
   a_full_only_stall : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (&vld_ff) && !rsp_tready)
      else $error("request stalled while a stage was free");

   // nothing comes out in the cycle after reset
   a_reset_empty : assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid right after reset");

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the 2D Catmull-Rom spline point evaluator.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import crsp_pkg::*;

   localparam int REQ_FILL_W   = REQ_W - REQ_FIELDS_W;
   localparam int RSP_FILL_W   = RSP_W - RSP_FIELDS_W;
   localparam int RANDOM_ITEMS = 1332;

   // field order matches the tdata layout, last field in the lowest bits
   typedef struct packed {
      logic [REQ_FILL_W-1:0] fill;
      param_type             param_s;
      coord_type             p4_y;
      coord_type             p4_x;
      coord_type             p3_y;
      coord_type             p3_x;
      coord_type             p2_y;
      coord_type             p2_x;
      coord_type             p1_y;
      coord_type             p1_x;
   } spline_req_type;

   typedef struct packed {
      logic [RSP_FILL_W-1:0] fill;
      logic                  saturated;
      coord_type             out_y;
      coord_type             out_x;
   } spline_rsp_type;

   typedef logic signed [127:0] wide_type;

   class spline_scoreboard;
      spline_rsp_type expected_points[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
      endfunction

      // exact Hermite evaluation of one axis, rounded half up, then clipped
      function coord_type eval_axis(coord_type c1, coord_type c2, coord_type c3,
                                    coord_type c4, param_type s, inout bit clipped);
         wide_type dif_a, dif_b, dif_d, k2, k3, sw, v, q, hi_lim, lo_lim;
         dif_a  = wide_type'(c3) - wide_type'(c1);
         dif_b  = wide_type'(c4) - wide_type'(c2);
         dif_d  = wide_type'(c3) - wide_type'(c2);
         k2     = 6 * dif_d - 2 * dif_a - dif_b;
         k3     = dif_a + dif_b - 4 * dif_d;
         sw     = wide_type'(s);
         hi_lim = wide_type'(coord_type'(COORD_MAX));
         lo_lim = wide_type'(coord_type'(COORD_MIN));
         v = ((k3 * sw + (k2 <<< 16)) * sw + (dif_a <<< 32)) * sw
             + (wide_type'(c2) <<< 49) + (wide_type'(1) <<< 48);
         q = v >>> 49;
         if (q > hi_lim) begin
            clipped = 1'b1;
            return coord_type'(COORD_MAX);
         end
         if (q < lo_lim) begin
            clipped = 1'b1;
            return coord_type'(COORD_MIN);
         end
         return coord_type'(q[COORD_W-1:0]);
      endfunction

      function void note_request(spline_req_type req);
         spline_rsp_type exp_pt;
         param_type      s;
         bit             clipped;
         s       = (req.param_s > PARAM_ONE) ? PARAM_ONE : req.param_s;
         clipped = 1'b0;
         exp_pt  = '0;
         exp_pt.out_x = eval_axis(req.p1_x, req.p2_x, req.p3_x, req.p4_x, s, clipped);
         exp_pt.out_y = eval_axis(req.p1_y, req.p2_y, req.p3_y, req.p4_y, s, clipped);
         exp_pt.saturated = clipped;
         expected_points.push_back(exp_pt);
      endfunction

      function void check_response(spline_rsp_type rsp);
         spline_rsp_type exp_pt;
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected response, expected none actual %h", $time, rsp);
            mismatches++;
            return;
         end
         exp_pt = expected_points.pop_front();
         if (rsp.out_x !== exp_pt.out_x) begin
            $display("%0t: out_x expected %h actual %h", $time, exp_pt.out_x, rsp.out_x);
            mismatches++;
         end
         if (rsp.out_y !== exp_pt.out_y) begin
            $display("%0t: out_y expected %h actual %h", $time, exp_pt.out_y, rsp.out_y);
            mismatches++;
         end
         if (rsp.saturated !== exp_pt.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time, exp_pt.saturated,
                     rsp.saturated);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return expected_points.size();
      endfunction
   endclass

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   int unsigned send_idle_pct = 19;
   int unsigned recv_idle_pct = 83;

   spline_scoreboard points = new();

   catmull_rom_spline_point u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // response side: check the transfer seen at this edge, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         points.check_response(rsp_tdata);
      end
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   task automatic send_item(input spline_req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= item;
      do @(posedge clock); while (!req_tready);
      points.note_request(item);
   endtask

   function automatic spline_req_type make_item(coord_type ax, coord_type ay, coord_type bx,
                                                coord_type by, coord_type cx, coord_type cy,
                                                coord_type dx, coord_type dy, param_type s);
      spline_req_type item;
      item         = '0;
      item.p1_x    = ax;
      item.p1_y    = ay;
      item.p2_x    = bx;
      item.p2_y    = by;
      item.p3_x    = cx;
      item.p3_y    = cy;
      item.p4_x    = dx;
      item.p4_y    = dy;
      item.param_s = s;
      return item;
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(9))
         0, 1, 2, 3: return coord_type'($urandom);
         4, 5, 6:    return coord_type'(int'($urandom_range(2097152)) - 1048576);
         7:          return coord_type'(COORD_MAX);
         8:          return coord_type'(COORD_MIN);
         default:    return coord_type'(int'($urandom_range(3)) - 2);
      endcase
   endfunction

   function automatic param_type rand_param();
      case ($urandom_range(19))
         0:       return '0;
         1:       return PARAM_ONE;
         2, 3:    return param_type'($urandom_range(131071, 65537));
         default: return param_type'($urandom_range(65536));
      endcase
   endfunction

   function automatic spline_req_type rand_item();
      spline_req_type item;
      coord_type      base_x, base_y;
      item = '0;
      case ($urandom_range(3))
         0: begin
            // unrelated full-range points
            item = make_item($urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom, rand_param());
         end
         1: begin
            // points clustered around a common origin, a typical curve segment
            base_x = $urandom;
            base_y = $urandom;
            item = make_item(base_x + coord_type'(int'($urandom_range(65535)) - 32768),
                             base_y + coord_type'(int'($urandom_range(65535)) - 32768),
                             base_x + coord_type'(int'($urandom_range(65535)) - 32768),
                             base_y + coord_type'(int'($urandom_range(65535)) - 32768),
                             base_x + coord_type'(int'($urandom_range(65535)) - 32768),
                             base_y + coord_type'(int'($urandom_range(65535)) - 32768),
                             base_x + coord_type'(int'($urandom_range(65535)) - 32768),
                             base_y + coord_type'(int'($urandom_range(65535)) - 32768),
                             rand_param());
         end
         default: begin
            item = make_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                             rand_param());
         end
      endcase
      return item;
   endfunction

   initial begin
      coord_type one, hi, lo;
      one = 32'sh0001_0000;
      hi  = coord_type'(COORD_MAX);
      lo  = coord_type'(COORD_MIN);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_item(make_item(0, 0, 0, 0, 0, 0, 0, 0, '0));
      send_item(make_item(0, 0, one, one, 2 * one, 3 * one, 4 * one, 2 * one, '0));
      send_item(make_item(0, 0, one, one, 2 * one, 3 * one, 4 * one, 2 * one, PARAM_ONE));
      send_item(make_item(0, 0, one, one, 2 * one, 3 * one, 4 * one, 2 * one, 17'd32768));
      // parameter above one is clamped
      send_item(make_item(0, 0, one, one, 2 * one, 3 * one, 4 * one, 2 * one, 17'd65537));
      send_item(make_item(0, 0, one, one, 2 * one, 3 * one, 4 * one, 2 * one, 17'h1FFFF));
      send_item(make_item(0, 0, one, one, 2 * one, 3 * one, 4 * one, 2 * one, 17'd1));
      send_item(make_item(0, 0, one, one, 2 * one, 3 * one, 4 * one, 2 * one, 17'd65535));
      send_item(make_item(hi, hi, hi, hi, hi, hi, hi, hi, 17'd32768));
      send_item(make_item(lo, lo, lo, lo, lo, lo, lo, lo, 17'd32768));
      // overshoot past both ends of the range
      send_item(make_item(lo, hi, hi, lo, hi, lo, lo, hi, 17'd32768));
      send_item(make_item(hi, lo, lo, hi, lo, hi, hi, lo, 17'd32768));
      // rounding ties at the midpoint: +0.5 lsb goes up, -0.5 lsb goes to zero
      send_item(make_item(-8, 8, 0, 0, 0, 0, 0, 0, 17'd32768));
      send_item(make_item(hi, lo, lo, hi, hi, lo, lo, hi, PARAM_ONE));
      send_item(make_item(hi, lo, lo, hi, hi, lo, lo, hi, 17'd21845));
      send_item(make_item(0, 0, lo, hi, hi, lo, 0, 0, '0));
      send_item(make_item(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                          32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA,
                          17'h15555));
      send_item(make_item(-1, -1, -1, -1, -1, -1, -1, -1, 17'h0AAAA));

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 19;
               recv_idle_pct = 83;
            end
            1: begin
               send_idle_pct = 83;
               recv_idle_pct = 19;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < RANDOM_ITEMS / 3; n++) begin
            send_item(rand_item());
         end
      end
      req_tvalid <= 1'b0;

      while (points.pending() != 0) @(posedge clock);
      repeat (NUM_STG + 4) @(posedge clock);
      if (points.mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
